[design/t2i_pkg.sv]
// shared types and constants for the 2d table interpolator
`default_nettype none
package t2i_pkg;
	localparam int MaxRowsDef = 128;
	localparam int MaxColsDef = 128;
	localparam logic [1:0] ACT_POINT  = 2'd0;
	localparam logic [1:0] ACT_HEADER = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE, ST_YRD0, ST_YCHK0, ST_YRDL, ST_YCHKL, ST_YSCAN, ST_YSCANW,
		ST_ROWSET, ST_RC, ST_RCW, ST_X0, ST_X0W, ST_XL, ST_XLW, ST_XSCAN, ST_XSCANW,
		ST_ROWLERP, ST_ROWDONE, ST_YLERP, ST_LERPW, ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
	} lerp_ctl_t;
endpackage
`default_nettype wire

[design/t2i_lerp.sv]
// one clamped linear step: serial divider then one multiply
`default_nettype none
module t2i_lerp
	import t2i_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire lerp_ctl_t   ctl,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	input  wire logic [31:0] za,
	input  wire logic [31:0] zb,
	input  wire logic [31:0] v,
	output logic             done,
	output logic [31:0]      z
);
	logic [1:0]  ph_q;
	logic [5:0]  cnt_q;
	logic [32:0] den_q, rem_q;
	logic [61:0] num_q;
	logic [30:0] w_q;
	logic [32:0] dz_q;
	logic [31:0] za_q;
	logic [64:0] p_q;
	logic [33:0] trial;
	logic [32:0] rem_sh;
	logic [32:0] vd;
	logic signed [63:0] prod_s;

	assign vd     = {v[31], v} - {a[31], a};
	assign rem_sh = {rem_q[31:0], num_q[61]};
	assign trial  = {1'b0, rem_sh} - {1'b0, den_q};
	assign prod_s = $signed({1'b0, w_q}) * $signed(dz_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 2'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (ph_q)
				2'd0: if (ctl.start) begin
					za_q <= za;
					dz_q <= {zb[31], zb} - {za[31], za};
					if ($signed(v) <= $signed(a)) begin
						z <= za; done <= 1'b1;
					end else if ($signed(v) >= $signed(b)) begin
						z <= zb; done <= 1'b1;
					end else begin
						den_q <= {b[31], b} - {a[31], a};
						// (v - a) scaled by 2^30
						num_q <= {vd[31:0], 30'd0};
						rem_q <= 33'd0;
						cnt_q <= 6'd0;
						ph_q  <= 2'd1;
					end
				end
				2'd1: begin
					if (!trial[33]) begin
						rem_q <= trial[32:0];
						w_q   <= {w_q[29:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						w_q   <= {w_q[29:0], 1'b0};
					end
					num_q <= {num_q[60:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd61) ph_q <= 2'd2;
				end
				2'd2: begin
					p_q  <= {prod_s[63], prod_s};
					ph_q <= 2'd3;
				end
				default: begin
					z    <= za_q + p_q[61:30];
					done <= 1'b1;
					ph_q <= 2'd0;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

[design/table_2d_interpolator.sv]
// top level: table memories and query sequencer
// channel | dir | handshake       | payload
// in      | in  | in_valid/stall  | action row col key_x key_y z_in row_points
// out     | out | out_valid/stall | z_out is_answer
// a write is acknowledged in the cycle after its transfer
// a query reads up to MAX_ROWS + 1 headers, up to MAX_COLS + 1 points in each of
// two rows, and runs three linear steps, each a serial divide then one multiply
// reset clears control only; the table is undefined until written
// in_stall is high while an item is in work or a result waits
`default_nettype none
module table_2d_interpolator
	import t2i_pkg::*;
#(
	parameter int MAX_ROWS = MaxRowsDef,
	parameter int MAX_COLS = MaxColsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [6:0]  row,
	input  wire logic [6:0]  col,
	input  wire logic [31:0] key_x,
	input  wire logic [31:0] key_y,
	input  wire logic [31:0] z_in,
	input  wire logic [7:0]  row_points,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      z_out,
	output logic             is_answer
);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam int GD = MAX_ROWS * MAX_COLS;

	logic [63:0] grid_mem [GD];
	logic [39:0] hdr_mem  [MAX_ROWS];
	logic [63:0] grid_rd_q;
	logic [39:0] hdr_rd_q;
	logic [RW-1:0] hdr_addr;
	logic [RW+CW-1:0] grid_addr;

	state_t st_q, st_d;
	logic [7:0]  rows_used_q;
	logic [31:0] kx_q, ky_q;
	logic [RW:0] n_q, j_q;
	logic [CW:0] c_q, i_q;
	logic [RW-1:0] r_q;
	logic        second_q, ylerp_q, single_q;
	logic [31:0] ya_q, yb_q, za0_q, za1_q;
	logic [31:0] xa_q, xb_q, zxa_q, zxb_q, xl_q, zl_q;
	logic        busy_q;
	lerp_ctl_t   lctl;
	logic        ldone;
	logic [31:0] lz;
	logic [31:0] la, lb, lza, lzb, lv;
	logic        acc;
	logic [RW:0] n_lim;
	logic [CW:0] c_lim;

	assign acc      = in_valid && !in_stall;
	assign in_stall = busy_q || out_valid;

	always_comb begin
		if (rows_used_q == 8'd0) n_lim = (RW+1)'(1);
		else if (32'(rows_used_q) > MAX_ROWS) n_lim = (RW+1)'(MAX_ROWS);
		else n_lim = (RW+1)'(rows_used_q);
		if (hdr_rd_q[7:0] == 8'd0) c_lim = (CW+1)'(1);
		else if (32'(hdr_rd_q[7:0]) > MAX_COLS) c_lim = (CW+1)'(MAX_COLS);
		else c_lim = (CW+1)'(hdr_rd_q[7:0]);
	end

	always_ff @(posedge clk) begin
		if (acc && action == ACT_POINT && 32'(row) < MAX_ROWS && 32'(col) < MAX_COLS)
			grid_mem[{row[RW-1:0], col[CW-1:0]}] <= {key_x, z_in};
		if (acc && action == ACT_HEADER && 32'(row) < MAX_ROWS)
			hdr_mem[row[RW-1:0]] <= {key_y, row_points};
		grid_rd_q <= grid_mem[grid_addr];
		hdr_rd_q  <= hdr_mem[hdr_addr];
	end

	// address selection per state
	always_comb begin
		hdr_addr  = r_q;
		grid_addr = {r_q, i_q[CW-1:0]};
		unique case (st_q)
			ST_YRD0:  hdr_addr = '0;
			ST_YRDL:  hdr_addr = RW'(n_q - 1'b1);
			ST_YSCAN: hdr_addr = j_q[RW-1:0];
			ST_X0:    grid_addr = {r_q, {CW{1'b0}}};
			ST_XL:    grid_addr = {r_q, CW'(c_q - 1'b1)};
			default: ;
		endcase
	end

	assign la  = ylerp_q ? ya_q  : xa_q;
	assign lb  = ylerp_q ? yb_q  : xb_q;
	assign lza = ylerp_q ? za0_q : zxa_q;
	assign lzb = ylerp_q ? za1_q : zxb_q;
	assign lv  = ylerp_q ? ky_q  : kx_q;

	t2i_lerp u_lerp (
		.clk(clk), .arst_n(arst_n), .ctl(lctl), .a(la), .b(lb), .za(lza), .zb(lzb),
		.v(lv), .done(ldone), .z(lz)
	);

	always_comb begin
		st_d = st_q;
		lctl.start = 1'b0;
		unique case (st_q)
			ST_IDLE:   if (acc && action == ACT_QUERY) st_d = ST_YRD0;
			ST_YRD0:   st_d = ST_YCHK0;
			ST_YCHK0:  st_d = ($signed(ky_q) <= $signed(hdr_rd_q[39:8])) ? ST_ROWSET : ST_YRDL;
			ST_YRDL:   st_d = ST_YCHKL;
			ST_YCHKL:  st_d = ($signed(ky_q) >= $signed(hdr_rd_q[39:8])) ? ST_ROWSET : ST_YSCAN;
			ST_YSCAN:  st_d = ST_YSCANW;
			ST_YSCANW: st_d = (j_q < n_q - 1'b1 && $signed(hdr_rd_q[39:8]) <= $signed(ky_q))
				? ST_YSCAN : ST_ROWSET;
			ST_ROWSET: st_d = ST_RC;
			ST_RC:     st_d = ST_RCW;
			ST_RCW:    st_d = ST_X0;
			ST_X0:     st_d = ST_X0W;
			ST_X0W:    st_d = ($signed(kx_q) <= $signed(grid_rd_q[63:32])) ? ST_ROWDONE : ST_XL;
			ST_XL:     st_d = ST_XLW;
			ST_XLW:    st_d = ($signed(kx_q) >= $signed(grid_rd_q[63:32])) ? ST_ROWDONE : ST_XSCAN;
			ST_XSCAN:  st_d = ST_XSCANW;
			ST_XSCANW: if (!(i_q < c_q - 1'b1 && $signed(grid_rd_q[63:32]) <= $signed(kx_q))) begin
				st_d = ST_ROWLERP;
			end else st_d = ST_XSCAN;
			ST_ROWLERP: begin lctl.start = 1'b1; st_d = ST_LERPW; end
			ST_LERPW:  if (ldone) st_d = ylerp_q ? ST_OUT : ST_ROWDONE;
			ST_ROWDONE: st_d = single_q ? ST_OUT : (second_q ? ST_YLERP : ST_ROWSET);
			ST_YLERP:  begin lctl.start = 1'b1; st_d = ST_LERPW; end
			ST_OUT:    st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; rows_used_q <= 8'd1; busy_q <= 1'b0; out_valid <= 1'b0;
			z_out <= 32'd0; is_answer <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) rows_used_q <= cfg_wdata;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (acc) begin
				if (action == ACT_QUERY) busy_q <= 1'b1;
				else begin out_valid <= 1'b1; z_out <= 32'd0; is_answer <= 1'b0; end
			end
			if (st_q == ST_OUT) begin
				busy_q <= 1'b0; out_valid <= 1'b1; is_answer <= 1'b1; z_out <= za0_q;
			end
		end
	end

	// datapath registers; single_q marks a query that uses one edge row alone
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: if (acc) begin
				kx_q <= key_x; ky_q <= key_y; n_q <= n_lim; second_q <= 1'b0; ylerp_q <= 1'b0;
				single_q <= 1'b0;
				j_q <= (RW+1)'(1);
			end
			ST_YCHK0: begin
				ya_q <= hdr_rd_q[39:8];
				if ($signed(ky_q) <= $signed(hdr_rd_q[39:8])) begin
					r_q <= '0; single_q <= 1'b1;
				end
			end
			ST_YCHKL: if ($signed(ky_q) >= $signed(hdr_rd_q[39:8])) begin
				r_q <= RW'(n_q - 1'b1); single_q <= 1'b1;
			end
			ST_YSCANW: if (j_q < n_q - 1'b1 && $signed(hdr_rd_q[39:8]) <= $signed(ky_q)) begin
				j_q <= j_q + 1'b1; ya_q <= hdr_rd_q[39:8];
			end else begin
				r_q <= RW'(j_q - 1'b1); yb_q <= hdr_rd_q[39:8];
			end
			ST_RC: i_q <= (CW+1)'(1);
			ST_RCW: c_q <= c_lim;
			ST_X0W: begin xl_q <= grid_rd_q[63:32]; zl_q <= grid_rd_q[31:0]; end
			ST_XLW: if ($signed(kx_q) >= $signed(grid_rd_q[63:32])) zl_q <= grid_rd_q[31:0];
			ST_XSCAN: begin xa_q <= xl_q; zxa_q <= zl_q; end
			ST_XSCANW: begin
				xb_q <= grid_rd_q[63:32]; zxb_q <= grid_rd_q[31:0];
				if (i_q < c_q - 1'b1 && $signed(grid_rd_q[63:32]) <= $signed(kx_q))
					i_q <= i_q + 1'b1;
				xl_q <= grid_rd_q[63:32]; zl_q <= grid_rd_q[31:0];
			end
			ST_LERPW: if (ldone) begin
				if (ylerp_q) za0_q <= lz; else zl_q <= lz;
			end
			ST_ROWDONE: begin
				if (single_q) za0_q <= zl_q;
				else if (!second_q) begin
					za0_q <= zl_q; second_q <= 1'b1; r_q <= j_q[RW-1:0];
				end else begin
					za1_q <= zl_q; ylerp_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

[design/t2i_checker.sv]
// port-level checks for the interpolator
`default_nettype none
module t2i_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] z_out,
	input wire logic        is_answer
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(z_out)) else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("accepted while result waits");
	a_ack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_answer |-> z_out == 32'd0) else $error("write ack nonzero");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("not busy after transfer");
endmodule
bind table_2d_interpolator t2i_checker u_chk (.*);
`default_nettype wire

[verif/tb_table_2d_interpolator.sv]
// testbench for the 2d table interpolator: table loads, queries, self-checking predictor
module tb_table_2d_interpolator
	import t2i_pkg::*;
();

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int NROWS = 128;
	localparam int NCOLS = 128;
	localparam int IDLE_LIMIT = 20000;
	localparam longint QMIN = -64'sd2147483648;
	localparam longint QMAX = 64'sd2147483647;

	typedef struct {
		logic [1:0]  act;
		logic [6:0]  r;
		logic [6:0]  c;
		logic [31:0] kx;
		logic [31:0] ky;
		logic [31:0] zi;
		logic [7:0]  pts;
	} item_t;

	typedef struct {
		logic [31:0] z;
		logic        ans;
	} answer_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;
	logic in_valid, in_stall;
	logic [1:0] action;
	logic [6:0] row, col;
	logic [31:0] key_x, key_y, z_in;
	logic [7:0] row_points;
	logic out_valid, out_stall;
	logic [31:0] z_out;
	logic is_answer;

	table_2d_interpolator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .action(action), .row(row), .col(col),
		.key_x(key_x), .key_y(key_y), .z_in(z_in), .row_points(row_points),
		.out_valid(out_valid), .out_stall(out_stall), .z_out(z_out), .is_answer(is_answer)
	);

	// predictor copy of the table
	int x_tab[NROWS][NCOLS];
	int z_tab[NROWS][NCOLS];
	int y_brk[NROWS];
	logic [7:0] pts_tab[NROWS];
	logic [7:0] active_rows;

	// shadow used only while building stimulus
	longint gen_x[NROWS][NCOLS];
	longint gen_y[NROWS];
	int gen_cnt[NROWS];

	item_t pending[$];
	answer_t answers_due[$];
	item_t drv_item;
	answer_t got;
	bit calm, hold;
	int mismatches, checked, queries_checked, idle_cycles;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint lerp1(longint a, longint b, longint za, longint zb,
		longint v);
		longint unsigned w;
		longint p;
		if (v <= a) return za;
		if (v >= b) return zb;
		w = (longint'(v - a) << 30) / longint'(b - a);
		p = longint'(w) * (zb - za);
		return za + (p >>> 30);
	endfunction

	function automatic longint row_z(int r, longint x);
		int n, i;
		n = pts_tab[r];
		i = 1;
		if (n == 0) n = 1;
		if (n > NCOLS) n = NCOLS;
		if (x <= x_tab[r][0]) return z_tab[r][0];
		if (x >= x_tab[r][n-1]) return z_tab[r][n-1];
		while (i < n - 1 && x_tab[r][i] <= x) i++;
		return lerp1(x_tab[r][i-1], x_tab[r][i], z_tab[r][i-1], z_tab[r][i], x);
	endfunction

	function automatic longint surface_z(longint x, longint y);
		int n, j;
		n = active_rows;
		j = 1;
		if (n == 0) n = 1;
		if (n > NROWS) n = NROWS;
		if (y <= y_brk[0]) return row_z(0, x);
		if (y >= y_brk[n-1]) return row_z(n - 1, x);
		while (j < n - 1 && y_brk[j] <= y) j++;
		return lerp1(y_brk[j-1], y_brk[j], row_z(j - 1, x), row_z(j, x), y);
	endfunction

	// reset and register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_rows <= 8'd1;
		end else if (cfg_we) begin
			active_rows <= cfg_wdata;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= '0;
			row <= '0;
			col <= '0;
			key_x <= '0;
			key_y <= '0;
			z_in <= '0;
			row_points <= '0;
		end else if (!in_valid || !in_stall) begin
			if (pending.size() > 0 && !hold && (calm || $urandom_range(99) >= 38)) begin
				drv_item = pending.pop_front();
				in_valid <= 1'b1;
				action <= drv_item.act;
				row <= drv_item.r;
				col <= drv_item.c;
				key_x <= drv_item.kx;
				key_y <= drv_item.ky;
				z_in <= drv_item.zi;
				row_points <= drv_item.pts;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 38);
		end
	end

	// input transfer: update the table copy and predict the answer
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			got.z = '0;
			got.ans = 1'b0;
			case (action)
				ACT_POINT: begin
					x_tab[row][col] = $signed(key_x);
					z_tab[row][col] = $signed(z_in);
				end
				ACT_HEADER: begin
					y_brk[row] = $signed(key_y);
					pts_tab[row] = row_points;
				end
				ACT_QUERY: begin
					got.z = 32'(surface_z(longint'($signed(key_x)), longint'($signed(key_y))));
					got.ans = 1'b1;
				end
				default: ;
			endcase
			answers_due.push_back(got);
		end
	end

	// output transfer: compare with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (answers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result z_out=%h is_answer=%b", z_out, is_answer);
			end else begin
				got = answers_due.pop_front();
				checked++;
				if (got.ans) queries_checked++;
				if (z_out !== got.z || is_answer !== got.ans) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected z=%h ans=%b, got z=%h ans=%b",
							got.z, got.ans, z_out, is_answer);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
			$display("table_2d_interpolator test failed");
			$finish;
		end
	end

	function automatic longint rand_q();
		return longint'($signed($urandom));
	endfunction

	function automatic longint rand_between(longint lo, longint hi);
		longint unsigned span;
		if (hi <= lo) return lo;
		span = hi - lo + 1;
		return lo + longint'({$urandom, $urandom} % span);
	endfunction

	task automatic push(logic [1:0] act, int r, int c, longint kx, longint ky,
		longint zi, int pts);
		item_t it;
		it.act = act;
		it.r = r[6:0];
		it.c = c[6:0];
		it.kx = kx[31:0];
		it.ky = ky[31:0];
		it.zi = zi[31:0];
		it.pts = pts[7:0];
		pending.push_back(it);
	endtask

	// breakpoints: mostly ascending, sometimes repeated, sometimes scrambled
	task automatic gen_axis(int n, bit ordered, ref longint v[$]);
		longint lo, step_max;
		v.delete();
		lo = rand_between(QMIN, 64'sd1073741824);
		step_max = (QMAX - lo) / (n + 1);
		for (int k = 0; k < n; k++) begin
			if (!ordered)
				v.push_back(rand_q());
			else if (k == 0)
				v.push_back(lo);
			else if ($urandom_range(19) == 0)
				v.push_back(v[k-1]);
			else
				v.push_back(v[k-1] + rand_between(1, step_max));
		end
	endtask

	task automatic write_row(int r, int pts, bit ordered);
		longint xs[$];
		int n;
		n = (pts == 0) ? 1 : ((pts > NCOLS) ? NCOLS : pts);
		gen_cnt[r] = n;
		gen_axis(n, ordered, xs);
		for (int k = 0; k < n; k++) begin
			gen_x[r][k] = xs[k];
			push(ACT_POINT, r, k, xs[k], rand_q(), rand_q(), $urandom_range(255));
		end
		push(ACT_HEADER, r, $urandom_range(127), rand_q(), gen_y[r], rand_q(), pts);
	endtask

	function automatic longint pick_near(longint pts_v[$]);
		int k;
		k = $urandom_range(pts_v.size() - 1);
		case ($urandom_range(9))
			0: return QMIN;
			1: return QMAX;
			2, 3: return pts_v[k];
			4, 5, 6, 7: begin
				if (k + 1 < pts_v.size() && pts_v[k+1] > pts_v[k])
					return rand_between(pts_v[k], pts_v[k+1]);
				return pts_v[k] + $signed($urandom_range(8)) - 4;
			end
			default: return rand_q();
		endcase
	endfunction

	task automatic add_query(int n);
		longint xs[$], ys[$];
		int r;
		r = $urandom_range(n - 1);
		for (int k = 0; k < gen_cnt[r]; k++) xs.push_back(gen_x[r][k]);
		for (int k = 0; k < n; k++) ys.push_back(gen_y[k]);
		push(ACT_QUERY, $urandom_range(127), $urandom_range(127), pick_near(xs),
			pick_near(ys), rand_q(), $urandom_range(255));
	endtask

	// writes that leave every entry a query can reach untouched
	task automatic add_noise(int n);
		case ($urandom_range(2))
			0: push(ACT_UNUSED, $urandom_range(127), $urandom_range(127), rand_q(), rand_q(),
				rand_q(), $urandom_range(255));
			1: if (n < NROWS)
				push(ACT_HEADER, $urandom_range(n, 127), $urandom_range(127), rand_q(),
					rand_q(), rand_q(), $urandom_range(255));
			default: if (n < NROWS)
				push(ACT_POINT, $urandom_range(n, 127), $urandom_range(127), rand_q(),
					rand_q(), rand_q(), $urandom_range(255));
		endcase
	endtask

	task automatic wait_drained();
		while (pending.size() != 0 || in_valid || answers_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_rows(int v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v[7:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(int cfg, int pts_kind, int nq, bit ordered);
		longint ys[$];
		int n;
		wait_drained();
		set_rows(cfg);
		n = (cfg == 0) ? 1 : ((cfg > NROWS) ? NROWS : cfg);
		gen_axis(n, ordered, ys);
		for (int r = 0; r < n; r++) begin
			gen_y[r] = ys[r];
			case (pts_kind)
				0: write_row(r, $urandom_range(2), ordered);
				1: write_row(r, $urandom_range(7), ordered || $urandom_range(3) != 0);
				default: write_row(r, (r == 0) ? 255 : 64, r == 0);
			endcase
		end
		for (int q = 0; q < nq; q++) begin
			if ($urandom_range(4) == 0) add_noise(n);
			add_query(n);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		calm = 1'b0;
		hold = 1'b0;
		mismatches = 0;
		checked = 0;
		queries_checked = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// one row of one point, rows_used of zero, count of zero, edge keys
		set_rows(0);
		gen_y[0] = 0;
		gen_cnt[0] = 1;
		gen_x[0][0] = 0;
		push(ACT_POINT, 0, 0, 0, 0, 32'h7fff_ffff, 0);
		push(ACT_HEADER, 0, 0, 0, 0, 0, 0);
		push(ACT_UNUSED, 127, 127, QMIN, QMAX, QMIN, 255);
		push(ACT_QUERY, 0, 0, QMIN, QMIN, 0, 0);
		push(ACT_QUERY, 0, 0, QMAX, QMAX, 0, 0);
		push(ACT_QUERY, 0, 0, QMIN, QMAX, 0, 0);
		push(ACT_QUERY, 0, 0, QMAX, QMIN, 0, 0);
		push(ACT_QUERY, 127, 127, 0, 0, -1, 255);
		push(ACT_POINT, 127, 127, -1, -1, 32'h8000_0000, 255);
		push(ACT_QUERY, 0, 0, 1, -1, 0, 0);

		// a full-width row with an over-range count, then a scrambled row
		run_phase(2, 2, 25, 1);
		// over-range rows_used with tiny rows
		run_phase(255, 0, 25, 1);
		calm = 1'b1;
		run_phase(4, 1, 20, 1);
		wait_drained();
		calm = 1'b0;
		for (int p = 0; p < 2; p++)
			run_phase($urandom_range(3, 12), 1, 40, p != 1);
		run_phase(1, 1, 20, 1);

		wait_drained();
		repeat (50) @(posedge clk);
		$display("checked %0d results, %0d of them query answers, over row counts 0 to 255",
			checked, queries_checked);
		if (mismatches == 0 && answers_due.size() == 0) begin
			$display("table_2d_interpolator test passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("table_2d_interpolator test failed");
		end
		$finish;
	end
endmodule
